FILE: design/chrs_pkg.sv
// ----------------------------------------------------------------------------
// chrs_pkg
// Types, mode codes, register indexes and band tables for the climate
// hysteresis relay scheduler.
// ----------------------------------------------------------------------------
package chrs_pkg;

   // Configuration register indexes
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 8;

   localparam logic [CSR_INDEX_W-1:0] CSR_HEAT_ON_BELOW   = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_HEAT_OFF_AT     = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_TOO_HOT_AT      = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_HUMID_ON_BELOW  = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_HUMID_OFF_AT    = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] CSR_MANUAL_OVERRIDE = 3'd5;
   localparam logic [CSR_INDEX_W-1:0] CSR_WAIT_FACTOR     = 3'd6;

   typedef enum logic [1:0] {
      TM_HEAT = 2'd0,
      TM_OK   = 2'd1,
      TM_HOT  = 2'd2
   } temp_mode_type;

   typedef enum logic {
      HM_HUMIDIFY = 1'b0,
      HM_OK       = 1'b1
   } humid_mode_type;

   typedef struct packed {
      logic signed [7:0] heat_on_below;
      logic signed [7:0] heat_off_at;
      logic signed [7:0] too_hot_at;
      logic [6:0]        humid_on_below;
      logic [6:0]        humid_off_at;
      logic              manual_override;
      logic [3:0]        wait_factor;
   } cfg_type;

   typedef struct packed {
      logic signed [11:0] temp_tenths;
      logic [9:0]         humid_tenths;
   } req_data_type;

   typedef struct packed {
      logic [5:0] heater_seconds;
      logic [4:0] humidifier_seconds;
      logic [5:0] circ_fan_seconds;
      logic [5:0] filter_fan_seconds;
      logic [9:0] wait_seconds;
      logic       overridden;
      logic [1:0] temp_mode;
      logic       humid_mode;
   } rsp_data_type;

   // Duration bands in seconds, entry 0 unused
   localparam logic [5:0] HEAT_TAB [6] = '{6'd0, 6'd8, 6'd14, 6'd19, 6'd26, 6'd35};
   localparam logic [4:0] HUM_TAB  [6] = '{5'd0, 5'd5, 5'd10, 5'd15, 5'd20, 5'd30};
   localparam logic [5:0] FAN_TAB  [6] = '{6'd0, 6'd10, 6'd20, 6'd30, 6'd40, 6'd50};

   localparam logic [9:0] IDLE_WAIT_S   = 10'd60;
   localparam logic [5:0] CIRC_EXTRA_S  = 6'd10;

endpackage

FILE: design/chrs_if.sv
// ----------------------------------------------------------------------------
// chrs_if
// Valid/ready channels for readings and schedule results.
// ----------------------------------------------------------------------------
interface chrs_req_if;
   import chrs_pkg::*;

   logic         valid;
   logic         ready;
   req_data_type data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

interface chrs_rsp_if;
   import chrs_pkg::*;

   logic         valid;
   logic         ready;
   rsp_data_type data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

FILE: design/chrs_calc.sv
// ----------------------------------------------------------------------------
// chrs_calc
// Hysteresis update, band lookup and relay schedule for one reading.
// ----------------------------------------------------------------------------
module chrs_calc (
   input  chrs_pkg::cfg_type        cfg,
   input  chrs_pkg::req_data_type   sample,
   input  chrs_pkg::temp_mode_type  temp_mode_cur,
   input  chrs_pkg::humid_mode_type humid_mode_cur,
   output chrs_pkg::temp_mode_type  temp_mode_nxt,
   output chrs_pkg::humid_mode_type humid_mode_nxt,
   output chrs_pkg::rsp_data_type   result
);
   import chrs_pkg::*;

   logic signed [12:0] t13;
   logic signed [12:0] on_t;
   logic signed [12:0] off_t;
   logic signed [12:0] hot_t;
   logic [10:0]        h11;
   logic [10:0]        on_h;
   logic [10:0]        off_h;
   logic signed [13:0] td;
   logic signed [11:0] hd;
   logic [2:0]         hb_idx;
   logic [2:0]         ub_idx;
   logic [2:0]         fb_idx;
   logic [5:0]         hb;
   logic [4:0]         ub;
   logic [5:0]         ub6;
   logic [5:0]         fb;
   logic [5:0]         heater;
   logic [4:0]         humid;
   logic [5:0]         circ;
   logic [5:0]         filter;
   logic [5:0]         wait_base;
   logic               wait_idle;
   logic [9:0]         wait_s;

   // thresholds scaled to tenths
   assign t13   = 13'(sample.temp_tenths);
   assign on_t  = 13'(cfg.heat_on_below) * 13'sd10;
   assign off_t = 13'(cfg.heat_off_at) * 13'sd10;
   assign hot_t = 13'(cfg.too_hot_at) * 13'sd10;
   assign h11   = {1'b0, sample.humid_tenths};
   assign on_h  = 11'({4'b0, cfg.humid_on_below} * 11'd10);
   assign off_h = 11'({4'b0, cfg.humid_off_at} * 11'd10);

   always_comb begin
      temp_mode_nxt = temp_mode_cur;
      if (t13 < on_t) begin
         temp_mode_nxt = TM_HEAT;
      end else if (t13 >= off_t && t13 < hot_t) begin
         temp_mode_nxt = TM_OK;
      end else if (t13 >= hot_t) begin
         temp_mode_nxt = TM_HOT;
      end
   end

   always_comb begin
      humid_mode_nxt = humid_mode_cur;
      if (h11 < on_h) begin
         humid_mode_nxt = HM_HUMIDIFY;
      end else if (h11 >= off_h) begin
         humid_mode_nxt = HM_OK;
      end
   end

   assign td = 14'(off_t) - 14'(t13);
   assign hd = $signed({1'b0, off_h}) - $signed({2'b00, sample.humid_tenths});

   always_comb begin
      if (td <= 14'sd5)       hb_idx = 3'd1;
      else if (td <= 14'sd10) hb_idx = 3'd2;
      else if (td <= 14'sd20) hb_idx = 3'd3;
      else if (td <= 14'sd30) hb_idx = 3'd4;
      else                    hb_idx = 3'd5;

      if (hd < 12'sd50)       ub_idx = 3'd1;
      else if (hd < 12'sd100) ub_idx = 3'd2;
      else if (hd < 12'sd150) ub_idx = 3'd3;
      else if (hd < 12'sd200) ub_idx = 3'd4;
      else                    ub_idx = 3'd5;

      // fan band only for moderate overshoot; everything else gets the top band
      if (td < -14'sd20 && td >= -14'sd40)       fb_idx = 3'd1;
      else if (td < -14'sd40 && td >= -14'sd60)  fb_idx = 3'd2;
      else if (td < -14'sd60 && td >= -14'sd80)  fb_idx = 3'd3;
      else if (td < -14'sd80 && td >= -14'sd100) fb_idx = 3'd4;
      else                                       fb_idx = 3'd5;
   end

   assign hb  = HEAT_TAB[hb_idx];
   assign ub  = HUM_TAB[ub_idx];
   assign ub6 = {1'b0, ub};
   assign fb  = FAN_TAB[fb_idx];

   // schedule uses the updated modes
   always_comb begin
      heater    = '0;
      humid     = '0;
      circ      = '0;
      filter    = '0;
      wait_base = '0;
      wait_idle = 1'b0;
      if (humid_mode_nxt == HM_HUMIDIFY) begin
         case (temp_mode_nxt)
            TM_HEAT: begin
               heater    = hb;
               humid     = ub;
               circ      = hb;
               wait_base = (hb >= ub6) ? hb : ub6;
            end
            TM_OK: begin
               humid     = ub;
               circ      = ub6;
               wait_base = ub6;
            end
            TM_HOT: begin
               humid     = ub;
               circ      = ub6 + CIRC_EXTRA_S;
               filter    = fb;
               wait_base = (fb >= ub6) ? fb : ub6;
            end
            default: begin
               wait_idle = 1'b1;
            end
         endcase
      end else begin
         case (temp_mode_nxt)
            TM_HOT: begin
               circ      = fb;
               filter    = fb;
               wait_base = fb;
            end
            TM_HEAT: begin
               heater    = hb;
               wait_base = hb;
            end
            default: begin
               wait_idle = 1'b1;
            end
         endcase
      end
   end

   assign wait_s = wait_idle ? IDLE_WAIT_S
                             : 10'({4'b0, wait_base} * {6'b0, cfg.wait_factor});

   always_comb begin
      result.overridden = cfg.manual_override;
      result.temp_mode  = temp_mode_nxt;
      result.humid_mode = humid_mode_nxt;
      if (cfg.manual_override) begin
         result.heater_seconds     = '0;
         result.humidifier_seconds = '0;
         result.circ_fan_seconds   = '0;
         result.filter_fan_seconds = '0;
         result.wait_seconds       = '0;
      end else begin
         result.heater_seconds     = heater;
         result.humidifier_seconds = humid;
         result.circ_fan_seconds   = circ;
         result.filter_fan_seconds = filter;
         result.wait_seconds       = wait_s;
      end
   end

endmodule

FILE: design/climate_hysteresis_relay_scheduler_top.sv
// ----------------------------------------------------------------------------
// climate_hysteresis_relay_scheduler_top
// Relay on-time scheduler driven by temperature and humidity hysteresis.
// ----------------------------------------------------------------------------
// A reading (temperature and humidity in tenths) is taken on every req_ch
// transfer and yields exactly one schedule on rsp_ch. The block sustains one
// reading per clock while rsp_ch is not stalled: a reading is captured in an
// input register, the hysteresis update, band lookup and schedule are worked
// out in combinational logic, and the schedule lands in a result register,
// which drives rsp_ch.valid. The result register decouples the two sides;
// req_ch.ready drops only when both the input and the result registers are
// full and the consumer is stalling, and it is held low during reset. The
// temperature and humidity modes advance as each reading moves into the
// result register, so readings are applied strictly in arrival order.
// Registers are written through csr_we / csr_index / csr_wdata (unused
// upper data bits ignored, unknown indexes dropped) and are expected to
// change only while the block is idle.
// ----------------------------------------------------------------------------
module climate_hysteresis_relay_scheduler_top (
   input  logic                                clock,
   input  logic                                reset,
   chrs_req_if.sink                            req_ch,
   chrs_rsp_if.source                          rsp_ch,
   input  logic                                csr_we,
   input  logic [chrs_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [chrs_pkg::CSR_DATA_W-1:0]     csr_wdata
);
   import chrs_pkg::*;

   cfg_type        cfg_ff;
   cfg_type        cfg_in;

   // input stage
   logic           s1_valid_ff;
   logic           s1_valid_in;
   req_data_type   s1_data_ff;

   // result stage
   logic           rsp_valid_ff;
   logic           rsp_valid_in;
   rsp_data_type   rsp_data_ff;

   // hysteresis state
   temp_mode_type  temp_mode_ff;
   humid_mode_type humid_mode_ff;
   temp_mode_type  temp_mode_in;
   humid_mode_type humid_mode_in;
   rsp_data_type   calc_result;

   logic           s1_advance;
   logic           req_xfer;

   // result slot frees when empty or being taken this cycle
   assign s1_advance = !rsp_valid_ff || rsp_ch.ready;
   assign req_ch.ready = !reset && (!s1_valid_ff || s1_advance);
   assign req_xfer = req_ch.valid && req_ch.ready;

   assign s1_valid_in  = req_xfer || (s1_valid_ff && !s1_advance);
   assign rsp_valid_in = (s1_valid_ff && s1_advance) || (rsp_valid_ff && !rsp_ch.ready);

   // register writes; only the low bits each register needs are kept
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_HEAT_ON_BELOW:   cfg_in.heat_on_below   = csr_wdata;
            CSR_HEAT_OFF_AT:     cfg_in.heat_off_at     = csr_wdata;
            CSR_TOO_HOT_AT:      cfg_in.too_hot_at      = csr_wdata;
            CSR_HUMID_ON_BELOW:  cfg_in.humid_on_below  = csr_wdata[6:0];
            CSR_HUMID_OFF_AT:    cfg_in.humid_off_at    = csr_wdata[6:0];
            CSR_MANUAL_OVERRIDE: cfg_in.manual_override = csr_wdata[0];
            CSR_WAIT_FACTOR:     cfg_in.wait_factor     = csr_wdata[3:0];
            default:             cfg_in = cfg_ff;
         endcase
      end
   end

   chrs_calc u_calc (
      .cfg            (cfg_ff),
      .sample         (s1_data_ff),
      .temp_mode_cur  (temp_mode_ff),
      .humid_mode_cur (humid_mode_ff),
      .temp_mode_nxt  (temp_mode_in),
      .humid_mode_nxt (humid_mode_in),
      .result         (calc_result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.heat_on_below   <= 8'sd10;
         cfg_ff.heat_off_at     <= 8'sd60;
         cfg_ff.too_hot_at      <= 8'sd80;
         cfg_ff.humid_on_below  <= 7'd10;
         cfg_ff.humid_off_at    <= 7'd40;
         cfg_ff.manual_override <= 1'b0;
         cfg_ff.wait_factor     <= 4'd4;
         s1_valid_ff            <= 1'b0;
         rsp_valid_ff           <= 1'b0;
         temp_mode_ff           <= TM_OK;
         humid_mode_ff          <= HM_OK;
      end else begin
         cfg_ff       <= cfg_in;
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         // modes commit as the reading moves into the result register
         if (s1_valid_ff && s1_advance) begin
            temp_mode_ff  <= temp_mode_in;
            humid_mode_ff <= humid_mode_in;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_xfer) begin
         s1_data_ff <= req_ch.data;
      end
      if (s1_valid_ff && s1_advance) begin
         rsp_data_ff <= calc_result;
      end
   end

   assign rsp_ch.valid = rsp_valid_ff;
   assign rsp_ch.data  = rsp_data_ff;

endmodule
